// File: src/assert_macros.svh
// Assertion macros shared by the matrix inverse RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: src/m3inv_pkg.sv
// Shared constants for the 3x3 matrix inverse pipeline.
package m3inv_pkg;
  localparam int unsigned ENTRY_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned NUM_ENTRIES     = 9;
endpackage

// File: src/m3inv_div.sv
// Pipelined restoring divider: one quotient bit per stage, operands travel along.
module m3inv_div #(
  parameter int unsigned NW  = 128,
  parameter int unsigned DW  = 96,
  parameter int unsigned QW  = 64,
  parameter int unsigned TW  = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [QW-1:0] quo,
  output logic [DW:0]   rem,
  output logic [DW-1:0] den_out,
  output logic [TW-1:0] tag_out
);
  // Stage arrays: remainder, shifted numerator, divisor, quotient, tag.
  logic [DW:0]   rem_r [QW+1];
  logic [NW-1:0] num_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic [TW-1:0] tag_r [QW+1];

  // The numerator top bits above QW form the starting remainder.
  always_comb begin
    rem_r[0] = (DW+1)'(num >> QW);
    num_r[0] = num << (NW - QW);
    den_r[0] = den;
    quo_r[0] = '0;
    tag_r[0] = tag_in;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW+1:0] shf;
    logic [DW+1:0] dif;
    assign shf = {rem_r[s], num_r[s][NW-1]};
    assign dif = shf - {2'b00, den_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= dif[DW+1] ? shf[DW:0] : dif[DW:0];
        num_r[s+1] <= num_r[s] << 1;
        den_r[s+1] <= den_r[s];
        quo_r[s+1] <= {quo_r[s][QW-2:0], ~dif[DW+1]};
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  assign quo     = quo_r[QW];
  assign rem     = rem_r[QW];
  assign den_out = den_r[QW];
  assign tag_out = tag_r[QW];
  `include "assert_macros.svh"
  `ASSERT_CLK(a_den_kept, clk, rst_n, !en |=> $stable(den_out), "divisor moved on stall")
  `ASSERT_CLK(a_quo_kept, clk, rst_n, !en |=> $stable(quo), "quotient moved on stall")
  `ASSERT_CLK(a_tag_move, clk, rst_n, !en |=> $stable(tag_out), "tag moved on stall")
endmodule

// File: src/matrix3_inverse_top.sv
// Top level: 3x3 inverse via adjugate, determinant and pipelined division.
// Path from accept to result: front stages, divider stages, then the rounding and output registers.
// Throughput: one matrix per cycle while the enable is high; every stage advances together under one enable.
// The enable drops only while the output register holds an untaken result.
// Reset clears the valid bits only; data registers are not reset.
module matrix3_inverse_top #(
  parameter int unsigned ENTRY_WIDTH = m3inv_pkg::ENTRY_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // a00,a01,a02,a10,a11,a12,a20,a21,a22 from lowest bit, padded to bytes
  input  logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // b00..b22 from lowest bit, padded to bytes
  output logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] out_tdata,
  // singular (bit 0), saturated (bit 1)
  output logic [1:0]              out_tuser
);
  localparam int unsigned W  = ENTRY_WIDTH;
  localparam int unsigned PW = 2*W;           // one product
  localparam int unsigned CW = 2*W + 1;       // cofactor
  localparam int unsigned DW = 3*W + 2;       // determinant
  localparam int unsigned NW = CW + 2*FRAC_BITS; // scaled numerator
  localparam int unsigned QW = W + 1;         // quotient bits kept
  localparam int unsigned XW = NW + DW;       // overflow compare width
  localparam int unsigned TDW = ((9*W+7)/8)*8;
  localparam int unsigned LAT = 6;
  localparam int unsigned TW = 3;             // overflow, sign, singular

  logic en;
  logic [LAT-1:0] vld_r;
  logic [QW:0]    dvld_r;

  // Stage 1: register inputs.
  logic signed [W-1:0] a_r [9];
  // Stage 2: eighteen products.
  logic signed [PW-1:0] p_r [9][2];
  logic signed [W-1:0]  a2_r [3];
  // Stage 3: cofactors.
  logic signed [CW-1:0] c_r [9];
  logic signed [W-1:0]  a3_r [3];
  // Stage 4: determinant partial products on the low and high cofactor halves.
  logic signed [2*W:0]  dl_r [3];
  logic signed [2*W:0]  dh_r [3];
  logic signed [CW-1:0] c4_r [9];
  // Stage 5: determinant terms.
  logic signed [DW-1:0] dp_r [3];
  logic signed [CW-1:0] c5_r [9];
  // Stage 6: determinant.
  logic signed [DW-1:0] det_r;
  logic signed [CW-1:0] c6_r [9];

  localparam int unsigned CT [9][4] = '{
    '{4,8,5,7}, '{2,7,1,8}, '{1,5,2,4},
    '{5,6,3,8}, '{0,8,2,6}, '{2,3,0,5},
    '{3,7,4,6}, '{1,6,0,7}, '{0,4,1,3}};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        a_r[k]    <= in_tdata[k*W +: W];
        p_r[k][0] <= a_r[CT[k][0]] * a_r[CT[k][1]];
        p_r[k][1] <= a_r[CT[k][2]] * a_r[CT[k][3]];
        c_r[k]    <= CW'(p_r[k][0]) - CW'(p_r[k][1]);
        c4_r[k]   <= c_r[k];
        c5_r[k]   <= c4_r[k];
        c6_r[k]   <= c5_r[k];
      end
      for (int k = 0; k < 3; k++) begin
        a2_r[k] <= a_r[k];
        a3_r[k] <= a2_r[k];
        dl_r[k] <= a3_r[k] * $signed({1'b0, c_r[3*k][W-1:0]});
        dh_r[k] <= a3_r[k] * $signed(c_r[3*k][CW-1:W]);
        dp_r[k] <= (DW'(dh_r[k]) <<< W) + DW'(dl_r[k]);
      end
      det_r <= dp_r[0] + dp_r[1] + dp_r[2];
    end
  end

  // Per-entry magnitude and sign; all nine share one determinant magnitude.
  logic [DW-1:0] dmag;
  assign dmag = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);

  logic [QW-1:0] q    [9];
  logic [DW:0]   rm   [9];
  logic [DW-1:0] dv   [9];
  logic [TW-1:0] tg   [9];
  for (genvar k = 0; k < 9; k++) begin : g_div
    logic [CW-1:0] cm;
    logic [NW-1:0] nn;
    logic          ovf;
    assign cm = c6_r[k][CW-1] ? CW'(-c6_r[k]) : CW'(c6_r[k]);
    assign nn = NW'(cm) << (2*FRAC_BITS);
    // The quotient needs more than QW bits when the top numerator part reaches the divisor.
    assign ovf = XW'(nn >> QW) >= XW'(dmag);
    m3inv_div #(.NW(NW), .DW(DW), .QW(QW), .TW(TW)) u_div (
      .clk(clk), .rst_n(rst_n), .en(en), .num(nn), .den(dmag),
      .tag_in({ovf, c6_r[k][CW-1] ^ det_r[DW-1], det_r == '0}),
      .quo(q[k]), .rem(rm[k]), .den_out(dv[k]), .tag_out(tg[k]));
  end

  // Rounding and saturation stage, then output register.
  logic [W-1:0] b_r [9];
  logic [8:0]   st_r;
  logic         sing_r;
  logic [TDW-1:0] od_r;
  logic [TDW-1:0] od_nxt;
  logic [1:0]     ou_r;
  logic           ov_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        logic [QW:0] qr;
        logic        big;
        qr  = {1'b0, q[k]} + (QW+1)'(({rm[k], 1'b0} >= {2'b00, dv[k]}) ? 1 : 0);
        big = tg[k][2] ||
              (tg[k][1] ? (qr > (QW+1)'(1) << (W-1)) : (qr >= (QW+1)'(1) << (W-1)));
        if (tg[k][0]) begin
          b_r[k] <= '0; st_r[k] <= 1'b0;
        end else if (big) begin
          b_r[k] <= tg[k][1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
          st_r[k] <= 1'b1;
        end else begin
          b_r[k] <= tg[k][1] ? W'(-qr) : W'(qr);
          st_r[k] <= 1'b0;
        end
      end
      sing_r <= tg[0][0];
    end
  end

  // Pack the nine entries, zero padded to whole bytes.
  always_comb begin
    od_nxt = '0;
    for (int k = 0; k < 9; k++) od_nxt[k*W +: W] = b_r[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      od_r <= od_nxt;
      ou_r <= {|st_r, sing_r};
    end
  end

  // Valid bits march with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      dvld_r <= '0;
      ov_r   <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[LAT-2:0], in_tvalid};
      dvld_r <= {dvld_r[QW-1:0], vld_r[LAT-1]};
      ov_r   <= dvld_r[QW];
    end
  end

  assign en         = !ov_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  `include "assert_macros.svh"
  `ASSERT_CLK(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> out_tvalid, "result dropped")
  `ASSERT_CLK(a_keep, clk, rst_n, (out_tvalid && !out_tready) |=> $stable(out_tdata), "data moved")
  `ASSERT_CLK(a_sing_zero, clk, rst_n, (out_tvalid && out_tuser[0]) |-> (out_tdata == '0), "singular")
  `ASSERT_CLK(a_ready, clk, rst_n, in_tready == (!out_tvalid || out_tready), "ready")
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the 3x3 matrix inverse pipeline.
module testbench;

  localparam int EW = m3inv_pkg::ENTRY_WIDTH_DEF;
  localparam int FB = m3inv_pkg::FRAC_BITS_DEF;
  localparam int DW = ((9 * EW + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;

  typedef logic signed [191:0] wide_t;

  // One expected inverse: the nine entries plus the singular and saturated flags.
  typedef struct {
    logic [DW-1:0] entries;
    logic          singular;
    logic          saturated;
  } inverse_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [DW-1:0] in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [DW-1:0] out_tdata;
  logic [1:0]    out_tuser;

  logic [DW-1:0] matrix_queue[$];
  inverse_t      inverse_queue[$];
  int            error_count = 0;
  int            sent_count = 0;
  int            taken_count = 0;
  int            idle_cycles;
  int            hold_left = 0;
  bit            hold_done = 1'b0;

  matrix3_inverse_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact adjugate inverse, rounded to nearest with ties away from zero.
  function automatic inverse_t invert_matrix(input logic [DW-1:0] data);
    wide_t a[9];
    wide_t cof[9];
    wide_t det, dmag, num, quo, rem, limit;
    logic neg;
    logic [EW-1:0] val;
    inverse_t res;
    a[0] = 0;
    for (int k = 0; k < 9; k++) begin
      a[k] = {{(192 - EW){data[k*EW+EW-1]}}, data[k*EW +: EW]};
    end
    cof[0] = a[4] * a[8] - a[5] * a[7];
    cof[1] = a[2] * a[7] - a[1] * a[8];
    cof[2] = a[1] * a[5] - a[2] * a[4];
    cof[3] = a[5] * a[6] - a[3] * a[8];
    cof[4] = a[0] * a[8] - a[2] * a[6];
    cof[5] = a[2] * a[3] - a[0] * a[5];
    cof[6] = a[3] * a[7] - a[4] * a[6];
    cof[7] = a[1] * a[6] - a[0] * a[7];
    cof[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    res.entries = '0;
    res.singular = 1'b0;
    res.saturated = 1'b0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    dmag = (det < 0) ? -det : det;
    limit = wide_t'(1) <<< (EW - 1);
    for (int k = 0; k < 9; k++) begin
      neg = (cof[k] < 0) != (det < 0);
      num = ((cof[k] < 0) ? -cof[k] : cof[k]) <<< (2 * FB);
      quo = num / dmag;
      rem = num % dmag;
      if ((rem <<< 1) >= dmag) quo = quo + 1;
      if (neg ? (quo > limit) : (quo >= limit)) begin
        res.saturated = 1'b1;
        val = neg ? {1'b1, {(EW - 1){1'b0}}} : {1'b0, {(EW - 1){1'b1}}};
      end else begin
        val = neg ? EW'(-quo) : EW'(quo);
      end
      res.entries[k*EW +: EW] = val;
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  task automatic add_matrix(input logic [EW-1:0] m[9]);
    logic [DW-1:0] d;
    d = '0;
    for (int k = 0; k < 9; k++) d[k*EW +: EW] = m[k];
    matrix_queue.push_back(d);
  endtask

  // Random matrices: mostly moderate values, plus singular, tiny and raw full-range ones.
  function automatic logic [DW-1:0] random_matrix();
    logic [DW-1:0] d;
    int pick, sh;
    d = '0;
    pick = $urandom_range(0, 99);
    sh = $urandom_range(4, 20);
    for (int k = 0; k < 9; k++) begin
      if (pick < 12) d[k*EW +: EW] = $urandom;
      else if (pick < 30) d[k*EW +: EW] = $signed($urandom_range(0, 16)) - 8;
      else d[k*EW +: EW] = $signed($urandom) >>> sh;
    end
    // Singular case: make one row a copy of another.
    if (pick >= 30 && pick < 40) d[6*EW +: 3*EW] = d[0 +: 3*EW];
    return d;
  endfunction

  // Sender: one transaction per accepted cycle, idle rate set by the run phase.
  always @(posedge clk) begin
    int idle_pct;
    idle_pct = (sent_count < 400) ? 14 : (sent_count < 800) ? 64 : 0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        inverse_queue.push_back(invert_matrix(in_tdata));
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (matrix_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= matrix_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and stalls at random or for a long hold.
  always @(posedge clk) begin
    inverse_t want;
    int stall_pct;
    stall_pct = (sent_count < 400) ? 64 : (sent_count < 800) ? 14 : 0;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        taken_count++;
        if (inverse_queue.size() == 0) begin
          report("unexpected result", 64'(out_tuser), 64'h0);
        end else begin
          want = inverse_queue.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (out_tdata[k*EW +: EW] !== want.entries[k*EW +: EW])
              report($sformatf("b%0d%0d", k / 3, k % 3),
                     64'(out_tdata[k*EW +: EW]), 64'(want.entries[k*EW +: EW]));
          end
          if (out_tuser[0] !== want.singular)
            report("singular", 64'(out_tuser[0]), 64'(want.singular));
          if (out_tuser[1] !== want.saturated)
            report("saturated", 64'(out_tuser[1]), 64'(want.saturated));
        end
      end
      if (!hold_done && taken_count == 150) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [EW-1:0] one, two, mx, mn;
    one = 32'h0001_0000;
    two = 32'h0002_0000;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    rst_n = 1'b0;

    // Directed matrices: identity, singular ones, extremes and clipping.
    add_matrix('{one, 0, 0, 0, one, 0, 0, 0, one});
    add_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_matrix('{mx, mx, mx, mx, mx, mx, mx, mx, mx});
    add_matrix('{mn, mn, mn, mn, mn, mn, mn, mn, mn});
    add_matrix('{mx, 0, 0, 0, mn, 0, 0, 0, one});
    add_matrix('{mn, 0, 0, 0, mn, 0, 0, 0, mn});
    add_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    add_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, 1});
    add_matrix('{two, 0, 0, 0, two, 0, 0, 0, -two});
    add_matrix('{0, -one, 0, one, 0, 0, 0, 0, one});
    add_matrix('{32'h0003_0000, one, 0, two, 32'h0005_0000, one, 0, one, 32'h0004_0000});
    add_matrix('{32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'haaaa_aaaa,
                 32'h5555_5555, 32'hfedc_ba98, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h5555_5555});
    add_matrix('{mx, mn, 0, mn, mx, 0, 0, 0, mx});
    add_matrix('{1, 2, 3, 4, 5, 6, 7, 8, 10});
    add_matrix('{one, two, 0, two, 32'h0004_0000, 0, 0, 0, one});
    add_matrix('{mx, 1, 0, 1, mx, 0, 0, 0, 1});
    for (int i = 0; i < 1200; i++) matrix_queue.push_back(random_matrix());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all stimulus to drain and all results to arrive.
    while (matrix_queue.size() > 0 || in_tvalid || inverse_queue.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: matrix3_inverse_top.f
+incdir+src
src/m3inv_pkg.sv
src/m3inv_div.sv
src/matrix3_inverse_top.sv
tb/testbench.sv
